// ----- rtl/dmc_pkg.sv -----
// Shared types and constants for the direct-mapped cache hit/miss model.
package dmc_pkg;

  // Configuration register widths.
  localparam int SET_BITS_W    = 4;
  localparam int OFFSET_BITS_W = 5;
  localparam int TAG_BITS_W    = 6;
  localparam int CYC_W         = 16;

  // Widest set index that set_bits can ask for.
  localparam int SET_W = (2 ** SET_BITS_W) - 1;

  // Register indexes (byte address / 4).
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SET_BITS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TAG_BITS     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HIT_TIME     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MISS_PENALTY = 3'd4;

  localparam logic [TAG_BITS_W-1:0] TAG_BITS_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_READ,
    ST_CHECK,
    ST_ACC
  } state_t;

endpackage

// ----- rtl/direct_mapped_cache_hit_miss_model.sv -----
// Direct-mapped cache hit/miss model with saturating cycle accounting.
//
// Each item on the slave stream is one address. The block strips offset_bits
// block-offset bits, takes the next set_bits bits as the set index (reduced
// modulo NUM_LINES) and the bits above as the tag, kept to tag_bits bits. It
// looks the line up in a single synchronous memory holding {valid, tag},
// reports hit or miss, and installs the tag on a miss. Every access adds
// hit_time to the cycle total; a miss also adds miss_penalty to both the
// cycle total and the miss total. Both totals saturate at all ones.
// Items go through one at a time, in order: index extraction with a reciprocal
// multiply, remainder, memory read, compare and write-back, then the saturating
// accumulate, which waits while the output register is full. The result sits in
// that output register, so the next item is taken while it waits.
// After reset the block runs a clearing pass over every line of the line memory
// and takes no item meanwhile (configuration writes still go in).
// Registers (APB, byte address 4*i): 0 set_bits, 1 offset_bits, 2 tag_bits,
// 3 hit_time, 4 miss_penalty. Configure only while the block is idle.
module direct_mapped_cache_hit_miss_model #(
  parameter int NUM_LINES   = 1024,
  parameter int ADDR_WIDTH  = 32,
  parameter int TOTAL_WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  // slave stream: address
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [((ADDR_WIDTH+7)/8)*8-1:0] s_tdata,   // [ADDR_WIDTH-1:0] address
  // master stream: result
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [((2*TOTAL_WIDTH+7)/8)*8-1:0] m_tdata, // cycle_total, miss_cycle_total
  output logic                     m_tuser,            // hit
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int OUT_W   = ((2 * TOTAL_WIDTH + 7) / 8) * 8;
  localparam int LINE_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int SET_W   = dmc_pkg::SET_W;
  localparam int EXT_W   = (ADDR_WIDTH > SET_W) ? ADDR_WIDTH : SET_W;
  localparam int RECIP_W = SET_W + 1;
  localparam int PROD_W  = SET_W + RECIP_W;
  localparam int MEM_W   = ADDR_WIDTH + 1;
  localparam int INC_W   = dmc_pkg::CYC_W + 1;
  // room for the total plus both charges without losing the carry
  localparam int SUM_W   = ((TOTAL_WIDTH > INC_W) ? TOTAL_WIDTH : INC_W) + 1;

  // floor(2^SET_W / NUM_LINES): quotient estimate is exact or one low.
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((2 ** SET_W) / NUM_LINES);
  localparam logic [31:0]        LINES_C = 32'(NUM_LINES);
  localparam logic [LINE_W-1:0]  LAST_LINE = LINE_W'(NUM_LINES - 1);

  // configuration
  logic [dmc_pkg::SET_BITS_W-1:0]    set_bits;
  logic [dmc_pkg::OFFSET_BITS_W-1:0] offset_bits;
  logic [dmc_pkg::TAG_BITS_W-1:0]    tag_bits;
  logic [dmc_pkg::CYC_W-1:0]         hit_time;
  logic [dmc_pkg::CYC_W-1:0]         miss_penalty;

  logic                              cfg_we;
  logic [dmc_pkg::REG_IDX_W-1:0]     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits     <= '0;
      offset_bits  <= '0;
      tag_bits     <= dmc_pkg::TAG_BITS_RESET;
      hit_time     <= '0;
      miss_penalty <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        dmc_pkg::REG_SET_BITS:     set_bits     <= pwdata[dmc_pkg::SET_BITS_W-1:0];
        dmc_pkg::REG_OFFSET_BITS:  offset_bits  <= pwdata[dmc_pkg::OFFSET_BITS_W-1:0];
        dmc_pkg::REG_TAG_BITS:     tag_bits     <= pwdata[dmc_pkg::TAG_BITS_W-1:0];
        dmc_pkg::REG_HIT_TIME:     hit_time     <= pwdata[dmc_pkg::CYC_W-1:0];
        dmc_pkg::REG_MISS_PENALTY: miss_penalty <= pwdata[dmc_pkg::CYC_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dmc_pkg::REG_SET_BITS:     prdata = 32'(set_bits);
      dmc_pkg::REG_OFFSET_BITS:  prdata = 32'(offset_bits);
      dmc_pkg::REG_TAG_BITS:     prdata = 32'(tag_bits);
      dmc_pkg::REG_HIT_TIME:     prdata = 32'(hit_time);
      dmc_pkg::REG_MISS_PENALTY: prdata = 32'(miss_penalty);
      default:                   prdata = '0;
    endcase
  end

  // control
  dmc_pkg::state_t state, state_next;

  logic              mem_re;
  logic              mem_we;
  logic [LINE_W-1:0] mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;
  logic              out_load;
  logic              out_free;

  logic [LINE_W-1:0] clr_idx;
  logic              clr_last;

  // datapath registers
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [PROD_W-1:0]     prod_q;
  logic [SET_W-1:0]      rem_q;
  logic [LINE_W-1:0]     line_q;
  logic                  hit_q;
  logic [TOTAL_WIDTH-1:0] cyc_acc;
  logic [TOTAL_WIDTH-1:0] miss_acc;

  assign clr_last = (clr_idx == LAST_LINE);
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dmc_pkg::ST_CLEAR: if (clr_last) state_next = dmc_pkg::ST_IDLE;
      dmc_pkg::ST_IDLE:  if (s_tvalid) state_next = dmc_pkg::ST_MUL;
      dmc_pkg::ST_MUL:   state_next = dmc_pkg::ST_REM;
      dmc_pkg::ST_REM:   state_next = dmc_pkg::ST_READ;
      dmc_pkg::ST_READ:  state_next = dmc_pkg::ST_CHECK;
      dmc_pkg::ST_CHECK: state_next = dmc_pkg::ST_ACC;
      dmc_pkg::ST_ACC:   if (out_free) state_next = dmc_pkg::ST_IDLE;
      default:           state_next = dmc_pkg::ST_CLEAR;
    endcase
  end

  // index extraction: set and masked tag
  logic [ADDR_WIDTH-1:0] above;
  logic [EXT_W-1:0]      above_ext;
  logic [SET_W-1:0]      set_val;
  logic [ADDR_WIDTH-1:0] tag_val;

  assign above     = addr_q >> offset_bits;
  assign above_ext = EXT_W'(above);
  assign set_val   = SET_W'(above_ext) & ~({SET_W{1'b1}} << set_bits);
  assign tag_val   = (above >> set_bits) & ~({ADDR_WIDTH{1'b1}} << tag_bits);

  // set % NUM_LINES by reciprocal: q estimate, remainder, one correction
  logic [RECIP_W-1:0] quot;
  logic [31:0]        quot_n;
  logic [31:0]        rem32;
  logic [31:0]        line_full;

  assign quot      = prod_q[PROD_W-1:SET_W];
  assign quot_n    = 32'(quot) * LINES_C;
  assign rem32     = 32'(rem_q);
  assign line_full = (rem32 >= LINES_C) ? (rem32 - LINES_C) : rem32;

  // line memory: {valid, tag}
  logic [MEM_W-1:0] line_mem [NUM_LINES];
  logic [MEM_W-1:0] mem_rdata;
  logic [LINE_W-1:0] mem_raddr;
  logic             lookup_hit;

  assign mem_raddr  = LINE_W'(line_full);
  assign lookup_hit = mem_rdata[ADDR_WIDTH] && (mem_rdata[ADDR_WIDTH-1:0] == tag_q);

  // outputs of the state machine
  always_comb begin
    s_tready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = line_q;
    mem_wdata = {1'b1, tag_q};
    out_load  = 1'b0;
    unique case (state)
      dmc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      dmc_pkg::ST_IDLE:  s_tready = 1'b1;
      dmc_pkg::ST_READ:  mem_re   = 1'b1;
      dmc_pkg::ST_CHECK: mem_we   = !lookup_hit;  // install on miss
      dmc_pkg::ST_ACC:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= line_mem[mem_raddr];
    end
  end

  // saturating accumulate
  logic [INC_W-1:0]         cyc_inc;
  logic [INC_W-1:0]         miss_inc;
  logic [SUM_W-1:0]         cyc_sum;
  logic [SUM_W-1:0]         miss_sum;
  logic [TOTAL_WIDTH-1:0]   cyc_acc_next;
  logic [TOTAL_WIDTH-1:0]   miss_acc_next;

  assign miss_inc = hit_q ? '0 : INC_W'(miss_penalty);
  assign cyc_inc  = INC_W'(hit_time) + miss_inc;
  assign cyc_sum  = SUM_W'(cyc_acc) + SUM_W'(cyc_inc);
  assign miss_sum = SUM_W'(miss_acc) + SUM_W'(miss_inc);
  assign cyc_acc_next  = (cyc_sum[SUM_W-1:TOTAL_WIDTH] != '0) ? '1 :
                         cyc_sum[TOTAL_WIDTH-1:0];
  assign miss_acc_next = (miss_sum[SUM_W-1:TOTAL_WIDTH] != '0) ? '1 :
                         miss_sum[TOTAL_WIDTH-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dmc_pkg::ST_CLEAR;
      clr_idx  <= '0;
      cyc_acc  <= '0;
      miss_acc <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dmc_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + LINE_W'(1);
      end
      if (out_load) begin
        cyc_acc  <= cyc_acc_next;
        miss_acc <= miss_acc_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      addr_q <= s_tdata[ADDR_WIDTH-1:0];
    end
    if (state == dmc_pkg::ST_MUL) begin
      set_q  <= set_val;
      tag_q  <= tag_val;
      prod_q <= PROD_W'(set_val) * PROD_W'(RECIP);
    end
    if (state == dmc_pkg::ST_REM) begin
      rem_q <= set_q - SET_W'(quot_n);
    end
    if (state == dmc_pkg::ST_READ) begin
      line_q <= mem_raddr;
    end
    if (state == dmc_pkg::ST_CHECK) begin
      hit_q <= lookup_hit;
    end
    if (out_load) begin
      m_tdata <= OUT_W'({miss_acc_next, cyc_acc_next});
      m_tuser <= hit_q;
    end
  end

`ifndef NO_ASSERTIONS
  // the cycle total only ever grows
  a_cyc_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> cyc_acc >= $past(cyc_acc))
    else $error("cycle total decreased");

  // miss cycles are a part of all charged cycles
  a_miss_le_cyc: assert property (@(posedge clk) disable iff (rst)
    miss_acc <= cyc_acc)
    else $error("miss total exceeds cycle total");

  // a hit leaves the miss total alone
  a_hit_no_penalty: assert property (@(posedge clk) disable iff (rst)
    out_load && hit_q |=> $stable(miss_acc))
    else $error("miss total changed on a hit");

  // the memory is only written on a miss or during the clearing pass
  a_write_on_miss: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == dmc_pkg::ST_CLEAR) || !lookup_hit)
    else $error("line written on a hit");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the direct-mapped cache hit/miss model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W    = 32;
  localparam int TOTAL_W   = 48;
  localparam int LINES     = 1024;
  localparam int QUIET_MAX = 4000;  // cycles with no handshake before giving up
  localparam int HOLD_LEN  = 300;   // long receiver stall, to back the block up

  // One expected lookup outcome, as carried on the result stream.
  typedef struct packed {
    logic               hit;
    logic [TOTAL_W-1:0] cycles;
    logic [TOTAL_W-1:0] miss_cycles;
  } lookup_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [ADDR_W-1:0]      s_tdata = '0;     // [31:0] address
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [2*TOTAL_W-1:0]   m_tdata;          // [47:0] cycle_total, [95:48] miss_cycle_total
  logic                   m_tuser;          // hit
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [4:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  direct_mapped_cache_hit_miss_model u_dut (.*);

  // Shadow copy of the cache state and the settings.
  logic [dmc_pkg::SET_BITS_W-1:0]    cfg_set_bits    = '0;
  logic [dmc_pkg::OFFSET_BITS_W-1:0] cfg_offset_bits = '0;
  logic [dmc_pkg::TAG_BITS_W-1:0]    cfg_tag_bits    = dmc_pkg::TAG_BITS_RESET;
  logic [dmc_pkg::CYC_W-1:0]         cfg_hit_time    = '0;
  logic [dmc_pkg::CYC_W-1:0]         cfg_miss_pen    = '0;
  bit                       line_valid [LINES];
  logic [63:0]              line_tag   [LINES];
  logic [TOTAL_W-1:0]       cycles_sum      = '0;
  logic [TOTAL_W-1:0]       miss_cycles_sum = '0;

  logic [ADDR_W-1:0] trace_q [$];       // addresses waiting to be driven
  lookup_result_t    lookup_q [$];      // outcomes waiting on the result stream
  int unsigned       n_queued   = 0;
  int unsigned       n_accepted = 0;
  int unsigned       n_errors   = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  bit                rx_hold   = 1'b0;
  bit                took_addr = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [dmc_pkg::CYC_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W + 1)'(b);
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

  // Work out hit/miss and the new totals for one address; update the shadow.
  task automatic model_cache_access(input logic [ADDR_W-1:0] addr);
    logic [63:0]    above, set_idx, tag;
    int unsigned    line;
    lookup_result_t r;
    above   = {32'b0, addr} >> cfg_offset_bits;
    set_idx = above & ((64'd1 << cfg_set_bits) - 64'd1);
    // tag_bits tops out at 63, so the shift never reaches 64
    tag     = (above >> cfg_set_bits) & ((64'd1 << cfg_tag_bits) - 64'd1);
    line    = 32'(set_idx % 64'(LINES));  // over-wide set index wraps
    r.hit   = line_valid[line] && (line_tag[line] == tag);
    cycles_sum = sat_add(cycles_sum, cfg_hit_time);
    if (!r.hit) begin
      cycles_sum       = sat_add(cycles_sum, cfg_miss_pen);
      miss_cycles_sum  = sat_add(miss_cycles_sum, cfg_miss_pen);
      line_valid[line] = 1'b1;
      line_tag[line]   = tag;
    end
    r.cycles      = cycles_sum;
    r.miss_cycles = miss_cycles_sum;
    lookup_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    n_errors++;
  endtask

  // Sample both streams at the rising edge; predict on input, check on output.
  always @(posedge clk) begin : observe
    lookup_result_t want;
    took_addr = !rst && s_tvalid && s_tready;
    if (took_addr) begin
      model_cache_access(s_tdata);
      n_accepted++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (lookup_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, m_tdata[63:0]);
      end else begin
        want = lookup_q.pop_front();
        if (m_tuser !== want.hit)
          report_mismatch("hit", 64'(want.hit), 64'(m_tuser));
        if (m_tdata[TOTAL_W-1:0] !== want.cycles)
          report_mismatch("cycle_total", 64'(want.cycles), 64'(m_tdata[TOTAL_W-1:0]));
        if (m_tdata[2*TOTAL_W-1:TOTAL_W] !== want.miss_cycles)
          report_mismatch("miss_cycle_total", 64'(want.miss_cycles),
                          64'(m_tdata[2*TOTAL_W-1:TOTAL_W]));
      end
    end
    // Watchdog: the clearing pass and the long stall both fit well inside QUIET_MAX.
    if (took_addr || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Timeout after %0d quiet cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Address driver: hold the item until taken, then maybe idle before the next.
  always @(negedge clk) begin : drive_addr
    logic              nxt_valid;
    logic [ADDR_W-1:0] nxt_data;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!s_tvalid || took_addr) begin
      nxt_valid = 1'b0;
      if (trace_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt_data  = trace_q.pop_front();
        nxt_valid = 1'b1;
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;
  end

  // Result receiver: random back-pressure, or a solid stall while rx_hold is set.
  always @(negedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic write_reg(input logic [dmc_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      dmc_pkg::REG_SET_BITS:     cfg_set_bits    = val[dmc_pkg::SET_BITS_W-1:0];
      dmc_pkg::REG_OFFSET_BITS:  cfg_offset_bits = val[dmc_pkg::OFFSET_BITS_W-1:0];
      dmc_pkg::REG_TAG_BITS:     cfg_tag_bits    = val[dmc_pkg::TAG_BITS_W-1:0];
      dmc_pkg::REG_HIT_TIME:     cfg_hit_time    = val[dmc_pkg::CYC_W-1:0];
      dmc_pkg::REG_MISS_PENALTY: cfg_miss_pen    = val[dmc_pkg::CYC_W-1:0];
      default: ;  // unmapped index, nothing changes
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_addr(input logic [ADDR_W-1:0] a);
    trace_q.push_back(a);
    n_queued++;
  endtask

  // Idle once every item is in and every outcome out, plus a pipeline margin.
  task automatic wait_drained();
    while (n_accepted != n_queued || lookup_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] pool [16];
    int unsigned       pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: no index, full 32-bit tag, nothing charged.
    push_addr(32'h0000_0000);
    push_addr(32'h0000_0000);
    push_addr(32'hFFFF_FFFF);
    push_addr(32'hFFFF_FFFF);
    push_addr(32'h1234_5678);
    wait_drained();

    // Largest charges; value bits above each register are dropped.
    write_reg(dmc_pkg::REG_HIT_TIME, 32'hFFFF_FFFF);
    write_reg(dmc_pkg::REG_MISS_PENALTY, 32'h0001_FFFF);
    write_reg(dmc_pkg::REG_SET_BITS, 32'd2);
    write_reg(dmc_pkg::REG_OFFSET_BITS, 32'd2);
    push_addr(32'h0000_0000);
    push_addr(32'h0000_0003);  // same block, other offset
    push_addr(32'h0000_0010);  // same set, new tag: evicts
    push_addr(32'h0000_0000);
    push_addr(32'h0000_0004);
    push_addr(32'hAAAA_AAAA);
    push_addr(32'h5555_5555);
    wait_drained();

    // Everything shifted out above the index: tag is zero; tag width beyond address.
    write_reg(dmc_pkg::REG_SET_BITS, 32'd15);
    write_reg(dmc_pkg::REG_OFFSET_BITS, 32'd31);
    write_reg(dmc_pkg::REG_TAG_BITS, 32'd63);
    push_addr(32'h8000_0000);
    push_addr(32'h0000_0000);
    push_addr(32'h8000_0000);
    push_addr(32'hFFFF_FFFF);
    wait_drained();

    // Zero tag width: any valid line hits.
    write_reg(dmc_pkg::REG_SET_BITS, 32'd10);
    write_reg(dmc_pkg::REG_OFFSET_BITS, 32'd0);
    write_reg(dmc_pkg::REG_TAG_BITS, 32'd0);
    push_addr(32'h0000_03FF);
    push_addr(32'hFFFF_F3FF);
    push_addr(32'h0000_0400);
    wait_drained();

    // Index wider than the line count wraps onto lower lines.
    write_reg(dmc_pkg::REG_SET_BITS, 32'd15);
    write_reg(dmc_pkg::REG_TAG_BITS, 32'd32);
    push_addr(32'h0000_7FFF);
    push_addr(32'h0000_03FF);
    wait_drained();

    // Writes past the last register must leave the settings alone.
    for (int r = dmc_pkg::REG_MISS_PENALTY + 1; r < (1 << dmc_pkg::REG_IDX_W); r++)
      write_reg(r[dmc_pkg::REG_IDX_W-1:0], 32'hFFFF_FFFF);
    push_addr(32'h0000_03FF);
    wait_drained();

    // Random part: three idling regimes, five settings each.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 76 : 0;
      rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 32 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        write_reg(dmc_pkg::REG_SET_BITS, $urandom);
        // mostly small block sizes so the index and tag stay busy
        write_reg(dmc_pkg::REG_OFFSET_BITS, ($urandom_range(3) == 0) ?
                  $urandom : (($urandom & ~32'h1F) | $urandom_range(6)));
        write_reg(dmc_pkg::REG_TAG_BITS, ($urandom_range(3) == 0) ?
                  $urandom : (($urandom & ~32'h3F) | $urandom_range(32, 12)));
        write_reg(dmc_pkg::REG_HIT_TIME, $urandom);
        write_reg(dmc_pkg::REG_MISS_PENALTY, $urandom);
        foreach (pool[i]) pool[i] = $urandom;
        // a small working set gives plenty of hits and conflict misses
        for (int n = 0; n < 100; n++) begin
          pick = $urandom_range(99);
          if (pick < 60)
            push_addr(pool[$urandom_range(15)] ^ $urandom_range(63));
          else if (pick < 75)
            push_addr(pool[$urandom_range(15)]);
          else
            push_addr($urandom);
        end
        if (ph == 2 && seg == 0) begin
          // receiver stalls while the sender keeps offering
          fork
            begin
              rx_hold = 1'b1;
              repeat (HOLD_LEN) @(posedge clk);
              rx_hold = 1'b0;
            end
          join_none
        end
        wait_drained();
      end
    end

    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
